// ===== hdl/jsr_pkg.sv =====
package jsr_pkg;

	// Job identifier width
	localparam int unsigned JOB_W  = 8;
	// Width of the fill field in a response beat
	localparam int unsigned FILL_W = 5;

	// Operation codes carried by a request beat
	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2,
		OP_NOP    = 2'd3
	} jsr_opcode_t;

	// Status codes returned with every response beat
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_EMPTY     = 2'd3
	} jsr_status_t;

	// Request beat
	typedef struct packed {
		jsr_opcode_t        opcode;
		logic [JOB_W-1:0]   job_value;
	} jsr_req_t;

	// Response beat
	typedef struct packed {
		jsr_status_t        status;
		logic               on_top;
		logic [FILL_W-1:0]  fill;
	} jsr_rsp_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic               push;
		logic               remove;
		logic [JOB_W-1:0]   value;
	} jsr_cmd_t;

endpackage

// ===== hdl/jsr_cell.sv =====
module jsr_cell (
	input  logic                     clk,
	input  logic                     arst_n,
	input  jsr_pkg::jsr_cmd_t        cmd,
	input  logic                     below_valid,
	input  logic                     hit_below,
	input  logic [jsr_pkg::JOB_W-1:0] above_entry,
	input  logic                     above_valid,
	output logic [jsr_pkg::JOB_W-1:0] entry,
	output logic                     valid,
	output logic                     hit_out,
	output logic                     match
);
	import jsr_pkg::*;

	logic [JOB_W-1:0] entry_q;
	logic             valid_q;
	logic             shift_down;
	logic             take_push;

	// A valid entry equal to the broadcast value counts as a match.
	assign match   = valid_q && (entry_q == cmd.value);
	// The hit flag ripples upwards: set once any cell at or below has matched.
	assign hit_out = hit_below | match;

	// On a remove every cell at or above the first match takes its upper neighbour.
	assign shift_down = cmd.remove && hit_out;
	// A push lands in the lowest empty cell, the one sitting on a valid cell.
	assign take_push  = cmd.push && !valid_q && below_valid;

	// Valid flag of this place in the stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take_push) begin
			valid_q <= 1'b1;
		end else if (shift_down) begin
			valid_q <= above_valid;
		end
	end

	// Stored identifier; only meaningful while valid.
	always_ff @(posedge clk) begin
		if (take_push) begin
			entry_q <= cmd.value;
		end else if (shift_down) begin
			entry_q <= above_entry;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;

endmodule

// ===== hdl/job_stack_with_remove_unit.sv =====
// Channel | Direction | Payload    | Handshake
// req     | in        | jsr_req_t  | req_valid / req_ready
// rsp     | out       | jsr_rsp_t  | rsp_valid / rsp_ready
//
// Every request beat is executed in the cycle it is accepted and its response
// beat is registered, so one beat per cycle is sustained while responses are taken.
// The DEPTH cells compare and shift in parallel, so only a held response slows the rate.
// Reset clears every valid flag and the fill count; the stack starts empty.
// A new request is taken while the response register is empty or being emptied.
module job_stack_with_remove_unit #(
	parameter int unsigned DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  jsr_pkg::jsr_req_t req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output jsr_pkg::jsr_rsp_t rsp
);
	import jsr_pkg::*;

	localparam int unsigned FW = $clog2(DEPTH + 1);

	logic              accept;
	jsr_cmd_t          cmd;
	logic [JOB_W-1:0]  entry   [DEPTH];
	logic [DEPTH-1:0]  valid;
	logic [DEPTH-1:0]  hit;
	logic [DEPTH-1:0]  match;
	logic [DEPTH-1:0]  top_hit;
	logic [FW-1:0]     fill_q;
	logic [FW-1:0]     fill_next;
	logic              full;
	logic              empty;
	logic              found;
	logic [31:0]       fill_wide;
	jsr_rsp_t          rsp_next;
	jsr_rsp_t          rsp_q;
	logic              rsp_valid_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign accept    = req_valid && req_ready;

	// Command broadcast to the cells, active only on an accepted beat.
	assign cmd.push   = accept && (req.opcode == OP_PUSH);
	assign cmd.remove = accept && (req.opcode == OP_REMOVE);
	assign cmd.value  = req.job_value;

	// Chain of cells, index 0 at the bottom of the stack.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic             below_valid;
		logic             hit_below;
		logic [JOB_W-1:0] above_entry;
		logic             above_valid;

		if (i == 0) begin : g_bottom
			assign below_valid = 1'b1;
			assign hit_below   = 1'b0;
		end else begin : g_mid_low
			assign below_valid = valid[i-1];
			assign hit_below   = hit[i-1];
		end

		if (i == DEPTH - 1) begin : g_top
			assign above_entry = '0;
			assign above_valid = 1'b0;
		end else begin : g_mid_high
			assign above_entry = entry[i+1];
			assign above_valid = valid[i+1];
		end

		// The top entry is the valid cell with no valid cell above it.
		assign top_hit[i] = match[i] && !above_valid;

		jsr_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.cmd         (cmd),
			.below_valid (below_valid),
			.hit_below   (hit_below),
			.above_entry (above_entry),
			.above_valid (above_valid),
			.entry       (entry[i]),
			.valid       (valid[i]),
			.hit_out     (hit[i]),
			.match       (match[i])
		);
	end

	assign full  = (fill_q == FW'(DEPTH));
	assign empty = (fill_q == '0);
	assign found = hit[DEPTH-1];

	// Next fill count and the response for the current request.
	always_comb begin
		fill_next       = fill_q;
		rsp_next.status = ST_OK;
		rsp_next.on_top = 1'b0;
		unique case (req.opcode)
			OP_PUSH: begin
				if (full) begin
					rsp_next.status = ST_FULL;
				end else begin
					fill_next = fill_q + FW'(1);
				end
			end
			OP_REMOVE: begin
				if (empty) begin
					rsp_next.status = ST_EMPTY;
				end else if (!found) begin
					rsp_next.status = ST_NOT_FOUND;
				end else begin
					fill_next = fill_q - FW'(1);
				end
			end
			OP_QUERY: begin
				if (empty) begin
					rsp_next.status = ST_EMPTY;
				end else begin
					rsp_next.on_top = |top_hit;
				end
			end
			default: begin
				rsp_next.status = ST_OK;
			end
		endcase
		fill_wide     = 32'(fill_next);
		rsp_next.fill = fill_wide[FILL_W-1:0];
	end

	// Fill count register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	// Response valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
